// ----- hw/rtl/ldr_pkg.sv -----
// ----------------------------------------------------------------------------
// ldr_pkg: shared types and constants for the longest distinct run block
// Alphabet size, counter widths, and the control/status/result structs that
// pass between the sequencer, the window datapath and the top level.
// ----------------------------------------------------------------------------
package ldr_pkg;

  localparam int SYM_BITS    = 8;              // alphabet index width
  localparam int ALPHA       = 1 << SYM_BITS;  // alphabet entries / ring depth
  localparam int CNT_BITS    = SYM_BITS + 1;   // window count, 0..ALPHA
  localparam int IN_SYM_BITS = 8;              // raw symbol field width
  localparam int LEN_BITS    = 9;              // length field width

  typedef logic [SYM_BITS-1:0]    sym_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;
  typedef logic [IN_SYM_BITS-1:0] raw_sym_t;
  typedef logic [LEN_BITS-1:0]    len_t;

  // sequencer -> datapath
  typedef struct packed {
    logic latch;   // take the input beat
    logic drop;    // retire oldest window symbol
    logic append;  // insert symbol, load result
  } cmd_t;

  // datapath -> sequencer
  typedef struct packed {
    logic hit;     // symbol already in a non-empty window
  } stat_t;

  // datapath -> output register
  typedef struct packed {
    cnt_t best;
    cnt_t window;
    logic done;
  } res_t;

  // low SYM_BITS bits of the raw symbol, zero-extended if the alphabet is wider
  function automatic sym_t sym_of(raw_sym_t s);
    logic [SYM_BITS+IN_SYM_BITS-1:0] w;
    begin
      w = {{SYM_BITS{1'b0}}, s};
      return w[SYM_BITS-1:0];
    end
  endfunction

endpackage

// ----- hw/rtl/ldr_ifs.sv -----
// ----------------------------------------------------------------------------
// ldr_ifs: valid/ready channels of the longest distinct run block
// Input beat carries one symbol with string marks; output beat one result.
// ----------------------------------------------------------------------------
interface ldr_in_if;
  import ldr_pkg::*;

  logic     valid;
  logic     ready;
  raw_sym_t symbol;
  logic     first;
  logic     final_req;

  modport source (output valid, symbol, first, final_req, input ready);
  modport sink (input valid, symbol, first, final_req, output ready);
endinterface

interface ldr_out_if;
  import ldr_pkg::*;

  logic valid;
  logic ready;
  len_t best_length;
  len_t window_length;
  logic done_res;

  modport source (output valid, best_length, window_length, done_res, input ready);
  modport sink (input valid, best_length, window_length, done_res, output ready);
endinterface

// ----- hw/rtl/ldr_ring.sv -----
// ----------------------------------------------------------------------------
// ldr_ring: window symbol ring
// One write port, one read port with registered read data. No reset.
// ----------------------------------------------------------------------------
module ldr_ring (
  input  logic          clk,
  input  logic          we,
  input  ldr_pkg::sym_t waddr,
  input  ldr_pkg::sym_t wdata,
  input  ldr_pkg::sym_t raddr,
  output ldr_pkg::sym_t rdata
);
  import ldr_pkg::*;

  sym_t mem [ALPHA];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/ldr_window.sv -----
// ----------------------------------------------------------------------------
// ldr_window: sliding window datapath
// Presence bitmap, ring pointers, window count and best length. Executes
// one sequencer command per cycle.
// ----------------------------------------------------------------------------
module ldr_window (
  input  logic              clk,
  input  logic              rst,
  input  ldr_pkg::cmd_t     cmd,
  input  ldr_pkg::raw_sym_t symbol,
  input  logic              first,
  input  logic              final_req,
  output ldr_pkg::stat_t    stat,
  output ldr_pkg::res_t     res
);
  import ldr_pkg::*;

  logic [ALPHA-1:0] present;
  sym_t             sym;
  logic             last;
  sym_t             oldest;
  cnt_t             count;
  cnt_t             best;

  sym_t rd_sym;
  sym_t tail;
  cnt_t count_inc;
  cnt_t best_next;

  // ring is read at the oldest position every cycle; a drop uses the value
  // sampled during the preceding check cycle
  ldr_ring u_ring (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (tail),
    .wdata (sym),
    .raddr (oldest),
    .rdata (rd_sym)
  );

  assign tail      = oldest + count[SYM_BITS-1:0];
  assign count_inc = count + cnt_t'(1);
  assign best_next = (count_inc > best) ? count_inc : best;

  assign stat.hit   = present[sym] && (count != '0);
  assign res.best   = best_next;
  assign res.window = count_inc;
  assign res.done   = last;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sym  <= sym_of(symbol);
      last <= final_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      oldest  <= '0;
      count   <= '0;
      best    <= '0;
    end else if (cmd.latch) begin
      if (first) begin
        present <= '0;
        oldest  <= '0;
        count   <= '0;
        best    <= '0;
      end
    end else if (cmd.drop) begin
      present[rd_sym] <= 1'b0;
      oldest          <= oldest + sym_t'(1);
      count           <= count - cnt_t'(1);
    end else if (cmd.append) begin
      present[sym] <= 1'b1;
      count        <= count_inc;
      best         <= best_next;
    end
  end

endmodule

// ----- hw/rtl/ldr_seq.sv -----
// ----------------------------------------------------------------------------
// ldr_seq: item sequencer
// Accept, then alternate check/drop until the symbol is absent, then append.
// ----------------------------------------------------------------------------
module ldr_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           out_free,
  input  ldr_pkg::stat_t stat,
  output logic           in_ready,
  output ldr_pkg::cmd_t  cmd
);
  import ldr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DROP
  } state_t;

  state_t state;

  assign in_ready   = (state == S_IDLE);
  assign cmd.latch  = (state == S_IDLE) && in_valid;
  assign cmd.drop   = (state == S_DROP);
  assign cmd.append = (state == S_CHECK) && !stat.hit && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (stat.hit) begin
            state <= S_DROP;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_DROP: begin
          state <= S_CHECK;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/longest_distinct_run_length.sv -----
// ----------------------------------------------------------------------------
// longest_distinct_run_length: longest repeat-free run tracker
// Streams a string one symbol per beat and reports, per symbol, the length
// of the repeat-free window ending there and the best length so far.
// ----------------------------------------------------------------------------
// Usage:
//   items   - input beats: symbol (low SYM_BITS bits used), first marks the
//             start of a new string (clears window and best), final_req
//             marks the last symbol and comes back as done_res.
//   results - one beat per input beat, in order: best_length,
//             window_length, done_res.
// Flow: after its accept, an item runs one check and one drop step per
//   window symbol it pushes out, then a last check whose append step loads
//   its result once the result register is free; the sequencer then goes
//   idle and the next item can be accepted. A symbol is inserted once and
//   dropped at most once. items.ready is high only while the sequencer is
//   idle; one item is worked on at a time.
// Stall: the result register holds a beat until results.ready; the next
//   item is accepted and worked meanwhile, and waits only at its append
//   step for the register to free up.
// Reset: rst (sync, active high) clears the presence bitmap, pointers,
//   counts and the result valid at once; no clearing pass. The ring
//   itself has no reset, only entries inside the window are ever used.
// ----------------------------------------------------------------------------
module longest_distinct_run_length (
  input logic       clk,
  input logic       rst,
  ldr_in_if.sink    items,
  ldr_out_if.source results
);
  import ldr_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  res_t  res;
  logic  out_free;

  // result register is free when empty or being drained this cycle
  assign out_free = !results.valid || results.ready;

  ldr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (items.ready),
    .cmd      (cmd)
  );

  ldr_window u_window (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .symbol    (items.symbol),
    .first     (items.first),
    .final_req (items.final_req),
    .stat      (stat),
    .res       (res)
  );

  // output beat register; lengths reported modulo the field width
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (cmd.append) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      results.best_length   <= len_t'(res.best);
      results.window_length <= len_t'(res.window);
      results.done_res      <= res.done;
    end
  end

  // never overwrite a result beat that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> (!results.valid || results.ready))
    else $error("result loaded over a pending beat");

  // an accepted item makes the block busy: items.ready goes low after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready) |=> !items.ready)
    else $error("input accepted on back-to-back cycles");

  // a drop only follows a check that found the symbol in the window
  a_drop_on_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.drop |-> $past(stat.hit))
    else $error("drop without a presence hit");

  // window length is nonzero and never exceeds the best length at load
  a_window_le_best: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> (res.window <= res.best) && (res.window != '0))
    else $error("window length out of range");

endmodule

// ----- tb/sv/longest_distinct_run_length_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// longest_distinct_run_length_tb: self-checking bench for the run tracker
// Streams strings of symbols, predicts window and best lengths per beat with
// a sliding-window tracker of its own, and compares every result in order.
// ----------------------------------------------------------------------------
module longest_distinct_run_length_tb;
  import ldr_pkg::*;

  // one expected result beat
  typedef struct packed {
    len_t best;
    len_t window;
    logic done;
  } run_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own window (presence map + ring of symbols) and a
  // queue of the result beats that the accepted symbols must produce.
  // --------------------------------------------------------------------------
  class run_tracker;
    bit          present [ALPHA];
    sym_t        ring [ALPHA];
    int unsigned oldest;
    int unsigned count;
    int unsigned best;
    run_result_t expected_runs [$];
    int unsigned mismatches;

    function new();
      foreach (ring[i]) ring[i] = '0;
      clear_string();
      mismatches = 0;
    endfunction

    function void clear_string();
      foreach (present[i]) present[i] = 1'b0;
      oldest = 0;
      count  = 0;
      best   = 0;
    endfunction

    // accepted input beat: work out the result it must cause
    function void note_symbol(raw_sym_t raw, logic first, logic last);
      logic [SYM_BITS+IN_SYM_BITS-1:0] wide;
      sym_t        sym;
      run_result_t res;
      wide = raw;
      sym  = wide[SYM_BITS-1:0];
      if (first) clear_string();
      // retire oldest symbols until the new one is no longer in the window
      while (present[sym] && count > 0) begin
        present[ring[oldest]] = 1'b0;
        oldest = (oldest + 1) % ALPHA;
        count--;
      end
      ring[(oldest + count) % ALPHA] = sym;
      present[sym] = 1'b1;
      count++;
      if (count > best) best = count;
      res.best   = len_t'(best);
      res.window = len_t'(count);
      res.done   = last;
      expected_runs.push_back(res);
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // accepted result beat: compare against the oldest expectation
    task check_result(len_t best_len, len_t win_len, logic done);
      run_result_t exp_res;
      if (expected_runs.size() == 0) begin
        flag_mismatch("result beat with no symbol waiting");
        return;
      end
      exp_res = expected_runs.pop_front();
      if (best_len !== exp_res.best)
        flag_mismatch($sformatf("best_length %0d, expected %0d", best_len, exp_res.best));
      if (win_len !== exp_res.window)
        flag_mismatch($sformatf("window_length %0d, expected %0d",
                                win_len, exp_res.window));
      if (done !== exp_res.done)
        flag_mismatch($sformatf("done_res %0b, expected %0b", done, exp_res.done));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ldr_in_if  items_if ();
  ldr_out_if results_if ();

  longest_distinct_run_length i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  run_tracker tracker = new();

  // idle percentages of the current phase, out of 100
  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned symbols_sent  = 0;

  // --------------------------------------------------------------------------
  // Sender. valid is left high after a beat so back-to-back beats never see
  // a low/high pair of writes in one step; a gap or a drain lowers it.
  // --------------------------------------------------------------------------
  task automatic send_beat(raw_sym_t sym, logic first, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      items_if.valid <= 1'b0;
      @(posedge clk);
    end
    items_if.valid     <= 1'b1;
    items_if.symbol    <= sym;
    items_if.first     <= first;
    items_if.final_req <= last;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    tracker.note_symbol(sym, first, last);
    symbols_sent++;
  endtask

  // One string: symbols drawn from a span of the alphabet starting at a
  // random base; the narrower the span, the more repeats and drops.
  // noisy strings get random first/final marks anywhere.
  task automatic send_string(int unsigned len, int unsigned span, bit start_mark,
                             bit end_mark, bit noisy);
    int unsigned base;
    logic        first;
    logic        last;
    base = $urandom_range(255);
    for (int unsigned k = 0; k < len; k++) begin
      first = (k == 0) && start_mark;
      last  = (k == len - 1) && end_mark;
      if (noisy) begin
        first = ($urandom_range(5) == 0);
        last  = ($urandom_range(5) == 0);
      end
      send_beat(raw_sym_t'(base + $urandom_range(span - 1)), first, last);
    end
  endtask

  // Whole alphabet in shuffled order: window and best grow to the full
  // ring depth, then a repeat of the oldest and of a middle symbol.
  task automatic send_permutation();
    raw_sym_t perm [ALPHA];
    raw_sym_t tmp;
    int unsigned j;
    foreach (perm[i]) perm[i] = raw_sym_t'(i);
    for (int i = ALPHA - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    foreach (perm[i]) send_beat(perm[i], i == 0, 1'b0);
    send_beat(perm[0], 1'b0, 1'b0);    // drops exactly one, stays full
    send_beat(perm[100], 1'b0, 1'b1);  // drops about a hundred
  endtask

  // sender holds off until every expected result has come back
  task automatic wait_drained();
    items_if.valid <= 1'b0;
    while (tracker.expected_runs.size() != 0) @(posedge clk);
  endtask

  // mostly well-formed strings, with some continuation and noise
  task automatic random_phase(int unsigned budget);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned spans [6] = '{2, 4, 8, 16, 32, 256};
    stop_at = symbols_sent + budget;
    while (symbols_sent < stop_at) begin
      kind = $urandom_range(9);
      if (kind <= 5)
        send_string($urandom_range(24, 1), spans[$urandom_range(5)], 1'b1, 1'b1, 1'b0);
      else if (kind <= 7)
        send_string($urandom_range(40, 1), 256, 1'b1, $urandom_range(1), 1'b0);
      else if (kind == 8)
        send_string($urandom_range(12, 1), spans[$urandom_range(5)], 1'b0,
                    $urandom_range(1), 1'b0);
      else
        send_string($urandom_range(8, 1), spans[$urandom_range(3)], 1'b0, 1'b0, 1'b1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: sample the result beat at the edge, then pick ready for the
  // next cycle.
  // --------------------------------------------------------------------------
  initial begin
    results_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && results_if.valid && results_if.ready)
        tracker.check_result(results_if.best_length, results_if.window_length,
                             results_if.done_res);
      results_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    items_if.valid     = 1'b0;
    items_if.symbol    = '0;
    items_if.first     = 1'b0;
    items_if.final_req = 1'b0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: no first mark since reset, extremes, repeats, marks
    send_beat(8'h00, 1'b0, 1'b0);  // starts a string from the reset state
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);  // repeat of the oldest
    send_beat(8'hAA, 1'b0, 1'b0);
    send_beat(8'h55, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b1);  // repeat of the oldest, end of string
    send_beat(8'h55, 1'b0, 1'b0);  // continues the old string, no first mark
    send_beat(8'h01, 1'b0, 1'b1);
    send_beat(8'h55, 1'b1, 1'b0);  // fresh string, old window must be gone
    send_beat(8'h7F, 1'b1, 1'b1);  // single-symbol string
    send_beat(8'h11, 1'b1, 1'b0);
    send_beat(8'h11, 1'b0, 1'b0);  // same symbol back to back
    send_beat(8'h11, 1'b0, 1'b0);
    send_beat(8'h80, 1'b0, 1'b0);
    send_beat(8'h11, 1'b0, 1'b0);
    send_beat(8'h80, 1'b0, 1'b1);
    send_beat(8'hFE, 1'b1, 1'b0);
    send_beat(8'h01, 1'b0, 1'b0);
    send_beat(8'h02, 1'b0, 1'b0);
    send_beat(8'hFD, 1'b0, 1'b0);
    send_beat(8'hFE, 1'b0, 1'b0);  // drops the oldest, window keeps length
    send_beat(8'h01, 1'b1, 1'b1);  // first and final on one beat
    wait_drained();

    // phase 1: no idling on either side, plus the full-alphabet string
    send_permutation();
    random_phase(140);
    wait_drained();

    // phase 2: sender idles
    src_idle_pct   = 48;
    sink_stall_pct = 0;
    random_phase(140);
    wait_drained();

    // phase 3: receiver stalls
    src_idle_pct   = 0;
    sink_stall_pct = 48;
    random_phase(140);
    wait_drained();

    // phase 4: both sides idle
    src_idle_pct   = 32;
    sink_stall_pct = 32;
    random_phase(140);

    // drain, then give any stray beat time to show up
    wait_drained();
    repeat (600) @(posedge clk);
    if (tracker.expected_runs.size() != 0)
      tracker.flag_mismatch("results still expected at end of run");
    if (tracker.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
